@@ sv/cyclic_signal_phase_timer_core_defines.svh @@
// Assertion macros for the cyclic signal phase timer checker.
// Depends on nothing; included by the checker file only.
`ifndef CYCLIC_SIGNAL_PHASE_TIMER_CORE_DEFINES_SVH
`define CYCLIC_SIGNAL_PHASE_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSPTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSPTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/csptc_pkg.sv @@
// Shared types, codes and reset constants of the cyclic signal phase timer.
// Used by the interfaces, the submodules and the top level.
package csptc_pkg;

  localparam int TIME_BITS  = 16;
  localparam int DELTA_W    = 10;
  localparam int START_W    = 16;
  localparam int OUT_TIME_W = 16;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int GROUPS     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION = 3'd0,
    CFG_PAUSE    = 3'd1,
    CFG_G0_VEH   = 3'd2,
    CFG_G0_WALK  = 3'd3,
    CFG_G1_VEH   = 3'd4,
    CFG_G1_WALK  = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] VEH_GREEN  = 2'd0;
  localparam logic [1:0] VEH_AMBER  = 2'd1;
  localparam logic [1:0] VEH_RED    = 2'd2;
  localparam logic       WALK_RED   = 1'b0;
  localparam logic       WALK_GREEN = 1'b1;

  localparam logic [START_W-1:0]   DURATION_RST = 16'd30000;
  localparam logic [CFG_DATA_W-1:0] G0_VEH_RST  = {16'd15000, 16'd12000, 16'd0};
  localparam logic [31:0]           G0_WALK_RST = {16'd28000, 16'd17000};
  localparam logic [CFG_DATA_W-1:0] G1_VEH_RST  = {16'd30000, 16'd27000, 16'd15000};
  localparam logic [31:0]           G1_WALK_RST = {16'd13000, 16'd2000};

  typedef struct packed {
    logic [1:0] veh;
    logic       walk;
  } lights_t;

  typedef struct packed {
    logic [START_W-1:0] green;
    logic [START_W-1:0] amber;
    logic [START_W-1:0] red;
    logic [START_W-1:0] walk_green;
    logic [START_W-1:0] walk_red;
  } starts_t;

endpackage

@@ sv/csptc_if.sv @@
// Handshake channels of the cyclic signal phase timer: tick words in, result words out.
// Depends on csptc_pkg for field widths.
interface csptc_tick_if;
  logic                             valid;
  logic                             ready;
  logic [csptc_pkg::DELTA_W-1:0]    delta_ms;

  modport source (output valid, output delta_ms, input ready);
  modport sink   (input valid, input delta_ms, output ready);
endinterface

interface csptc_result_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        group0_vehicle;
  logic                              group0_walk;
  logic [1:0]                        group1_vehicle;
  logic                              group1_walk;
  logic [csptc_pkg::OUT_TIME_W-1:0]  cycle_time_ms;

  modport source (output valid, output group0_vehicle, output group0_walk,
                  output group1_vehicle, output group1_walk, output cycle_time_ms,
                  input ready);
  modport sink   (input valid, input group0_vehicle, input group0_walk,
                  input group1_vehicle, input group1_walk, input cycle_time_ms,
                  output ready);
endinterface

@@ sv/csptc_wrap.sv @@
// Cycle time advance: adds the tick delta and wraps once by the cycle duration, giving zero if one wrap
// is not enough; while paused the time holds. Depends on csptc_pkg for widths.
module csptc_wrap #(
  parameter int TimeBits = csptc_pkg::TIME_BITS
) (
  input  logic [TimeBits-1:0]           time_i,
  input  logic [csptc_pkg::DELTA_W-1:0] delta_i,
  input  logic [csptc_pkg::START_W-1:0] duration_i,
  input  logic                          pause_i,
  output logic [TimeBits-1:0]           time_o
);

  localparam int CW = (TimeBits > csptc_pkg::START_W) ? TimeBits : csptc_pkg::START_W;
  localparam int SW = CW + 1;

  typedef logic [SW-1:0] sum_t;

  sum_t sum;
  sum_t dur;
  sum_t diff;

  assign sum  = sum_t'(time_i) + sum_t'(delta_i);
  assign dur  = sum_t'(duration_i);
  assign diff = sum - dur;

  always_comb begin
    if (pause_i) begin
      time_o = time_i;
    end else if (sum < dur) begin
      time_o = sum[TimeBits-1:0];
    end else if (diff >= dur) begin
      time_o = '0;
    end else begin
      time_o = diff[TimeBits-1:0];
    end
  end

endmodule

@@ sv/csptc_group.sv @@
// Light selection for one signal group from its start times and the cycle time.
// Depends on csptc_pkg for the light codes and the start and light structs.
module csptc_group #(
  parameter int TimeBits = csptc_pkg::TIME_BITS
) (
  input  logic [TimeBits-1:0]           time_i,
  input  logic [csptc_pkg::START_W-1:0] duration_i,
  input  csptc_pkg::starts_t            starts_i,
  input  csptc_pkg::lights_t            held_i,
  output csptc_pkg::lights_t            next_o
);

  localparam int CW = (TimeBits > csptc_pkg::START_W) ? TimeBits : csptc_pkg::START_W;

  typedef logic [CW-1:0] cmp_t;

  cmp_t       tt;
  cmp_t       gs;
  cmp_t       as;
  cmp_t       rs;
  cmp_t       dd;
  cmp_t       pg;
  cmp_t       pr;
  cmp_t       vcand [4];
  cmp_t       wcand [3];
  cmp_t       vbest;
  cmp_t       wbest;
  logic       vfound;
  logic       wfound;
  logic [1:0] veh;
  logic       walk;

  assign tt = cmp_t'(time_i);
  assign gs = cmp_t'(starts_i.green);
  assign as = cmp_t'(starts_i.amber);
  assign rs = cmp_t'(starts_i.red);
  assign dd = cmp_t'(duration_i);
  assign pg = cmp_t'(starts_i.walk_green);
  assign pr = cmp_t'(starts_i.walk_red);

  assign vcand[0] = gs;
  assign vcand[1] = as;
  assign vcand[2] = rs;
  assign vcand[3] = dd;
  assign wcand[0] = pg;
  assign wcand[1] = pr;
  assign wcand[2] = dd;

  always_comb begin
    vfound = 1'b0;
    vbest  = '0;
    for (int i = 0; i < 4; i++) begin
      if (vcand[i] > tt && (!vfound || vcand[i] < vbest)) begin
        vbest  = vcand[i];
        vfound = 1'b1;
      end
    end
    wfound = 1'b0;
    wbest  = '0;
    for (int i = 0; i < 3; i++) begin
      if (wcand[i] > tt && (!wfound || wcand[i] < wbest)) begin
        wbest  = wcand[i];
        wfound = 1'b1;
      end
    end
  end

  always_comb begin
    if (vbest == gs) begin
      veh = csptc_pkg::VEH_RED;
    end else if (vbest == as) begin
      veh = csptc_pkg::VEH_GREEN;
    end else if (vbest == rs) begin
      veh = csptc_pkg::VEH_AMBER;
    end else begin
      veh = csptc_pkg::VEH_GREEN;
      if (as > gs) begin
        veh = csptc_pkg::VEH_AMBER;
      end
      if (rs > ((veh == csptc_pkg::VEH_AMBER) ? as : gs)) begin
        veh = csptc_pkg::VEH_RED;
      end
    end

    if (wbest == pg) begin
      walk = csptc_pkg::WALK_RED;
    end else if (wbest == pr) begin
      walk = csptc_pkg::WALK_GREEN;
    end else begin
      walk = (pg > pr) ? csptc_pkg::WALK_GREEN : csptc_pkg::WALK_RED;
    end

    next_o = held_i;
    if (vfound && wfound) begin
      next_o.veh  = veh;
      next_o.walk = walk;
    end
  end

endmodule

@@ sv/cyclic_signal_phase_timer_core.sv @@
// Top level of the cyclic signal phase timer: configuration, state and handshake stages.
// Depends on csptc_pkg, csptc_if, csptc_wrap and csptc_group.
//
//   channel  | direction | word contents
//   ---------+-----------+-------------------------------------------------------
//   tick_i   | in        | delta_ms
//   result_o | out       | group0/1 vehicle and walk lights, cycle_time_ms
//
// One word per cycle is accepted and one result per cycle delivered while the result is not stalled.
// A word is held in the input register and moves to the result register once that register is free;
// the add, wrap and light selection between them form the only state loop.
// Reset loads the default configuration, zero cycle time and red lights.
// A stalled result holds, one more word waits in the input register, then ready drops.
module cyclic_signal_phase_timer_core #(
  parameter int TimeBits = csptc_pkg::TIME_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  csptc_tick_if.sink                       tick_i,
  csptc_result_if.source                   result_o,
  input  logic                             cfg_we_i,
  input  logic [csptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csptc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [csptc_pkg::START_W-1:0]    duration_q;
  logic                             pause_q;
  logic [csptc_pkg::CFG_DATA_W-1:0] veh_starts_q  [csptc_pkg::GROUPS];
  logic [31:0]                      walk_starts_q [csptc_pkg::GROUPS];

  logic                          in_valid_q;
  logic [csptc_pkg::DELTA_W-1:0] delta_q;
  logic                          out_valid_q;
  logic                          out_free;
  logic                          advance;

  logic [TimeBits-1:0]  time_q;
  logic [TimeBits-1:0]  time_d;
  csptc_pkg::lights_t   held_q [csptc_pkg::GROUPS];
  csptc_pkg::lights_t   held_d [csptc_pkg::GROUPS];
  csptc_pkg::starts_t   starts [csptc_pkg::GROUPS];

  csptc_pkg::lights_t                 res_lights_q [csptc_pkg::GROUPS];
  logic [csptc_pkg::OUT_TIME_W-1:0]   res_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q       <= csptc_pkg::DURATION_RST;
      pause_q          <= 1'b0;
      veh_starts_q[0]  <= csptc_pkg::G0_VEH_RST;
      walk_starts_q[0] <= csptc_pkg::G0_WALK_RST;
      veh_starts_q[1]  <= csptc_pkg::G1_VEH_RST;
      walk_starts_q[1] <= csptc_pkg::G1_WALK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csptc_pkg::CFG_DURATION: duration_q       <= cfg_data_i[csptc_pkg::START_W-1:0];
        csptc_pkg::CFG_PAUSE:    pause_q          <= cfg_data_i[0];
        csptc_pkg::CFG_G0_VEH:   veh_starts_q[0]  <= cfg_data_i;
        csptc_pkg::CFG_G0_WALK:  walk_starts_q[0] <= cfg_data_i[31:0];
        csptc_pkg::CFG_G1_VEH:   veh_starts_q[1]  <= cfg_data_i;
        csptc_pkg::CFG_G1_WALK:  walk_starts_q[1] <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && out_free;
  assign tick_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_valid_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      delta_q <= tick_i.delta_ms;
    end
  end

  csptc_wrap #(
    .TimeBits (TimeBits)
  ) u_wrap (
    .time_i     (time_q),
    .delta_i    (delta_q),
    .duration_i (duration_q),
    .pause_i    (pause_q),
    .time_o     (time_d)
  );

  for (genvar g = 0; g < csptc_pkg::GROUPS; g++) begin : g_group
    assign starts[g].green      = veh_starts_q[g][15:0];
    assign starts[g].amber      = veh_starts_q[g][31:16];
    assign starts[g].red        = veh_starts_q[g][47:32];
    assign starts[g].walk_green = walk_starts_q[g][15:0];
    assign starts[g].walk_red   = walk_starts_q[g][31:16];

    csptc_group #(
      .TimeBits (TimeBits)
    ) u_group (
      .time_i     (time_d),
      .duration_i (duration_q),
      .starts_i   (starts[g]),
      .held_i     (held_q[g]),
      .next_o     (held_d[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      held_q[0]   <= '{veh: csptc_pkg::VEH_RED, walk: csptc_pkg::WALK_RED};
      held_q[1]   <= '{veh: csptc_pkg::VEH_RED, walk: csptc_pkg::WALK_RED};
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        time_q    <= time_d;
        held_q[0] <= held_d[0];
        held_q[1] <= held_d[1];
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_lights_q[0] <= held_d[0];
      res_lights_q[1] <= held_d[1];
      res_time_q      <= csptc_pkg::OUT_TIME_W'(time_d);
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.group0_vehicle = res_lights_q[0].veh;
  assign result_o.group0_walk    = res_lights_q[0].walk;
  assign result_o.group1_vehicle = res_lights_q[1].veh;
  assign result_o.group1_walk    = res_lights_q[1].walk;
  assign result_o.cycle_time_ms  = res_time_q;

endmodule

@@ sv/csptc_checker.sv @@
// Port-level checks of the cyclic signal phase timer, bound to the top level.
// Depends on cyclic_signal_phase_timer_core_defines.svh for the assertion macros.
`include "cyclic_signal_phase_timer_core_defines.svh"

module csptc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  g0_veh_i,
  input logic        g0_walk_i,
  input logic [1:0]  g1_veh_i,
  input logic        g1_walk_i,
  input logic [15:0] time_i
);

  // A held result word keeps all of its fields.
  `CSPTC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(g0_veh_i) && $stable(g0_walk_i) && $stable(g1_veh_i) && $stable(g1_walk_i) && $stable(time_i), "result word changed while stalled")

  // With the result register empty the block must take a new word.
  `CSPTC_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i, "input not ready while result register empty")

  // An accepted tick passes the input register and then the result register and must show up as a valid result.
  `CSPTC_ASSERT_NOW(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i, ##2 out_valid_i, "accepted tick produced no result")

  // Vehicle lights never carry the unused code.
  `CSPTC_ASSERT_NOW(a_veh_code, clk_i, rst_ni, out_valid_i, g0_veh_i != 2'd3 && g1_veh_i != 2'd3, "vehicle light code out of range")

endmodule

bind cyclic_signal_phase_timer_core csptc_checker u_csptc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (tick_i.valid),
  .in_ready_i  (tick_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .g0_veh_i    (result_o.group0_vehicle),
  .g0_walk_i   (result_o.group0_walk),
  .g1_veh_i    (result_o.group1_vehicle),
  .g1_walk_i   (result_o.group1_walk),
  .time_i      (result_o.cycle_time_ms)
);
